// ----- rtl/obas_pkg.sv -----
// obas_pkg: shared constants, register codes and width helpers for the
// orthonormal basis pipeline. No dependencies.
package obas_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;   // input component width (Q4.12)
    localparam int INNER_MAX           = 20;   // widest component kept internally
    localparam int FRAC_BITS           = 12;   // fraction bits of input components
    localparam int RATIO_BITS          = 20;   // fraction bits of projection ratio
    localparam int NORM_BITS           = 30;   // fraction bits of squared direction cosine
    localparam int THRESH_W            = 34;   // parallel_threshold width
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(168);
    localparam int OUT_W               = 16;   // Q1.14 output component width
    localparam int VEC_GROWTH          = 5;    // headroom bits of working vectors
    localparam int PROJ_QUO_EXTRA      = RATIO_BITS + 1;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_ADDR_W          = 4;

    typedef enum logic
    {
        REG_THRESH = 1'b0
    } reg_idx_t;

    function automatic int inner_width(input int cw);
        return (cw > INNER_MAX) ? INNER_MAX : cw;
    endfunction

endpackage

// ----- rtl/obas_delay.sv -----
// obas_delay: enable-gated shift line for payload that rides beside a unit.
// No dependencies.
module obas_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

// ----- rtl/obas_div.sv -----
// obas_div: pipelined restoring divider, one quotient bit per stage.
// Requires num < den * 2^Q_W. No dependencies.
module obas_div #(
    parameter int NUM_W = 72,
    parameter int DEN_W = 52,
    parameter int Q_W   = 41
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    logic [DEN_W-1:0] rem_reg  [Q_W];
    logic [DEN_W-1:0] rem_next [Q_W];
    logic [DEN_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   low_reg  [Q_W];
    logic [Q_W-1:0]   quo_reg  [Q_W];
    logic [Q_W-1:0]   quo_next [Q_W];
    logic [NUM_W-1:0] top_bits;

    assign top_bits = num >> Q_W;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   low_in;
        logic [Q_W-1:0]   quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in = top_bits[DEN_W-1:0];
            assign den_in = den;
            assign low_in = num[Q_W-1:0];
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in, low_in[Q_W-1-k]};
        assign ge    = trial >= {1'b0, den_in};
        assign diff  = trial - {1'b0, den_in};
        assign rem_next[k] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_comb
        begin
            quo_next[k] = quo_in;
            quo_next[k][Q_W-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in;
                low_reg[k] <= low_in;
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

// ----- rtl/obas_proj.sv -----
// obas_proj: projection of y on u, p = round(trunc(y.u * 2^20 / u.u) * u / 2^20).
// Depends on obas_pkg, obas_div, obas_delay.
module obas_proj #(
    parameter int VW    = 21,
    parameter int QW    = 37,
    parameter int TAG_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [2:0][VW-1:0]    y,
    input  logic [2:0][VW-1:0]    u,
    input  logic [TAG_W-1:0]      tag_in,
    output logic                  out_vld,
    output logic [2:0][VW-1:0]    p,
    output logic [TAG_W-1:0]      tag_out
);

    localparam int PW    = 2 * VW + 2;
    localparam int NUM_W = PW + obas_pkg::RATIO_BITS;
    localparam int RW    = QW + 1;
    localparam int K     = RW / 2;
    localparam int HW    = RW - K;
    localparam int SW    = RW + VW + 1;
    localparam int LAT   = QW + 6;

    logic [LAT-1:0] vld_reg;

    // products and dot sums
    logic signed [2*VW-1:0] prod_yu_reg [3];
    logic signed [2*VW-1:0] prod_uu_reg [3];
    logic signed [PW-1:0]   d_reg;
    logic signed [PW-1:0]   n_reg;
    logic [PW-1:0]          absd_reg;
    logic [PW-1:0]          den_reg;
    logic                   neg_reg;
    logic                   nz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_yu_reg[i] <= $signed(y[i]) * $signed(u[i]);
                prod_uu_reg[i] <= $signed(u[i]) * $signed(u[i]);
            end
            d_reg <= PW'(prod_yu_reg[0]) + PW'(prod_yu_reg[1]) + PW'(prod_yu_reg[2]);
            n_reg <= PW'(prod_uu_reg[0]) + PW'(prod_uu_reg[1]) + PW'(prod_uu_reg[2]);
            absd_reg <= d_reg[PW-1] ? PW'(-d_reg) : PW'(d_reg);
            neg_reg  <= d_reg[PW-1];
            nz_reg   <= (n_reg != '0);
            den_reg  <= n_reg;
        end
    end

    logic [QW-1:0] quo;

    obas_div #(
        .NUM_W (NUM_W),
        .DEN_W (PW),
        .Q_W   (QW)
    ) u_div (
        .clk (clk),
        .en  (en),
        .num ({absd_reg, obas_pkg::RATIO_BITS'(0)}),
        .den (den_reg),
        .quo (quo)
    );

    logic [1:0] flags_d;

    obas_delay #(
        .W     (2),
        .DEPTH (QW)
    ) u_flags_dly (
        .clk (clk),
        .en  (en),
        .d   ({neg_reg, nz_reg}),
        .q   (flags_d)
    );

    logic [2:0][VW-1:0] u_d;

    obas_delay #(
        .W     (3 * VW),
        .DEPTH (QW + 4)
    ) u_vec_dly (
        .clk (clk),
        .en  (en),
        .d   (u),
        .q   (u_d)
    );

    obas_delay #(
        .W     (TAG_W),
        .DEPTH (LAT)
    ) u_tag_dly (
        .clk (clk),
        .en  (en),
        .d   (tag_in),
        .q   (tag_out)
    );

    // signed ratio, then split multiply and round
    logic signed [RW-1:0]     mag_s;
    logic signed [RW-1:0]     r_next;
    logic signed [RW-1:0]     r_reg;
    logic signed [K+VW:0]     pl_reg [3];
    logic signed [HW+VW-1:0]  ph_reg [3];
    logic signed [SW-1:0]     sum_w  [3];
    logic [2:0][VW-1:0]       p_reg;

    assign mag_s  = $signed({1'b0, quo});
    assign r_next = flags_d[0] ? (flags_d[1] ? -mag_s : mag_s) : '0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_w[i] = (SW'(ph_reg[i]) <<< K) + SW'(pl_reg[i])
                     + (SW'(1) <<< (obas_pkg::RATIO_BITS - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i] <= $signed({1'b0, r_reg[K-1:0]}) * $signed(u_d[i]);
                ph_reg[i] <= $signed(r_reg[RW-1:K]) * $signed(u_d[i]);
                p_reg[i]  <= sum_w[i][obas_pkg::RATIO_BITS +: VW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_vld};
        end
    end

    assign p       = p_reg;
    assign out_vld = vld_reg[LAT-1];

endmodule

// ----- rtl/obas_norm.sv -----
// obas_norm: scales one vector to Q1.14 unit length via per-component
// long division and pipelined integer square root. Depends on obas_pkg,
// obas_div, obas_delay.
module obas_norm #(
    parameter int VW = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic [2:0][VW-1:0]                u,
    output logic                              out_vld,
    output logic [2:0][obas_pkg::OUT_W-1:0]   e,
    output logic                              zero
);

    localparam int PW    = 2 * VW + 2;
    localparam int SQ_W  = 2 * VW;
    localparam int QW    = obas_pkg::NORM_BITS + 1;
    localparam int NUM_W = SQ_W + obas_pkg::NORM_BITS;
    localparam int STEPS = (QW + 1) / 2;
    localparam int RSW   = QW + 1;
    localparam int LAT   = QW + STEPS + 3;

    logic [LAT-1:0] vld_reg;

    logic signed [SQ_W-1:0] sq_s [3];
    logic [SQ_W-1:0]        sq_reg  [3];
    logic [SQ_W-1:0]        sq2_reg [3];
    logic [2:0]             neg1_reg;
    logic [2:0]             neg2_reg;
    logic                   nz2_reg;
    logic [PW-1:0]          n_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_s[i] = $signed(u[i]) * $signed(u[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]   <= sq_s[i];
                neg1_reg[i] <= u[i][VW-1];
                sq2_reg[i]  <= sq_reg[i];
            end
            neg2_reg <= neg1_reg;
            // length is zero exactly when every square is zero
            nz2_reg  <= |(sq_reg[0] | sq_reg[1] | sq_reg[2]);
            n_reg    <= PW'(sq_reg[0]) + PW'(sq_reg[1]) + PW'(sq_reg[2]);
        end
    end

    logic [3:0] flags_d;

    obas_delay #(
        .W     (4),
        .DEPTH (QW + STEPS)
    ) u_flags_dly (
        .clk (clk),
        .en  (en),
        .d   ({neg2_reg, nz2_reg}),
        .q   (flags_d)
    );

    logic [QW-1:0]  v_reg    [3][STEPS];
    logic [QW-1:0]  v_next   [3][STEPS];
    logic [RSW-1:0] res_reg  [3][STEPS];
    logic [RSW-1:0] res_next [3][STEPS];
    logic [RSW-1:0] mag      [3];
    logic [2:0][obas_pkg::OUT_W-1:0] e_next;
    logic [2:0][obas_pkg::OUT_W-1:0] e_reg;
    logic           zero_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        logic [QW-1:0] q_i;

        obas_div #(
            .NUM_W (NUM_W),
            .DEN_W (PW),
            .Q_W   (QW)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num ({sq2_reg[i], obas_pkg::NORM_BITS'(0)}),
            .den (n_reg),
            .quo (q_i)
        );

        for (genvar k = 0; k < STEPS; k++)
        begin : g_sqrt
            localparam logic [RSW-1:0] BIT = RSW'(1) << (2 * (STEPS - 1 - k));
            logic [QW-1:0]  v_in;
            logic [RSW-1:0] res_in;
            logic [RSW-1:0] trial;
            logic           ge;

            if (k == 0)
            begin : g_first
                assign v_in   = q_i;
                assign res_in = '0;
            end
            else
            begin : g_rest
                assign v_in   = v_reg[i][k-1];
                assign res_in = res_reg[i][k-1];
            end

            assign trial = res_in + BIT;
            assign ge    = {1'b0, v_in} >= trial;
            assign v_next[i][k]   = ge ? (v_in - trial[QW-1:0]) : v_in;
            assign res_next[i][k] = ge ? ((res_in >> 1) + BIT) : (res_in >> 1);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[i][k]   <= v_next[i][k];
                    res_reg[i][k] <= res_next[i][k];
                end
            end
        end

        assign mag[i] = (res_reg[i][STEPS-1] + RSW'(1)) >> 1;
        assign e_next[i] = !flags_d[0] ? '0 :
                           flags_d[1+i] ? obas_pkg::OUT_W'(-mag[i]) :
                                          obas_pkg::OUT_W'(mag[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg    <= e_next;
            zero_reg <= !flags_d[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_vld};
        end
    end

    assign e       = e_reg;
    assign zero    = zero_reg;
    assign out_vld = vld_reg[LAT-1];

endmodule

// ----- rtl/orthonormal_basis_3d_top.sv -----
// Orthonormal basis builder (3D Gram-Schmidt), one result beat per input beat.
// Takes one beat of three Q4.12 vectors a, b, c (or a alone, with opcode 1, to
// grow a basis around a) and returns three Q1.14 unit vectors plus a degenerate
// flag that is set when any intermediate vector has zero length; such a vector
// comes out as zero. The datapath is fully pipelined: one beat can be accepted
// every clock while s_tready is high, and each result lands in a two-entry
// output buffer. The depth comes from the bit-per-stage dividers inside the
// two projection steps and the normalizer (31 quotient stages plus 16
// square-root stages).
// s_tready drops only while that output buffer is full; backpressure freezes
// the whole pipeline, so nothing is lost or duplicated.
// The APB register parallel_threshold (byte address 0, 34 bits) sets the
// squared cross length, units 2^-24, at or below which +X replaces +Z as the
// helper axis in opcode 1. Write it only while the block is idle.
// Depends on obas_pkg, obas_proj, obas_norm, obas_delay, obas_div.
module orthonormal_basis_3d_top #(
    parameter int COMPONENT_WIDTH = obas_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (low to high), zero padded
    input  logic [((9*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    // opcode
    input  logic                                s_tuser,
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // e1_x, e1_y, e1_z, e2_x, e2_y, e2_z, e3_x, e3_y, e3_z (low to high)
    output logic [9*obas_pkg::OUT_W-1:0]        m_tdata,
    // degenerate
    output logic                                m_tuser,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [obas_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [obas_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [obas_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int IW     = obas_pkg::inner_width(CW);
    localparam int SH     = CW - IW;
    localparam int VW     = IW + obas_pkg::VEC_GROWTH;
    localparam int QW     = IW + obas_pkg::PROJ_QUO_EXTRA;
    localparam int IN_W   = 9 * CW;
    localparam int LW     = 2 * IW + 1;
    localparam int CMPW   = (LW > obas_pkg::THRESH_W) ? LW : obas_pkg::THRESH_W;
    localparam int OUT_DW = 9 * obas_pkg::OUT_W;
    localparam logic [VW-1:0] UNIT = VW'(1) << (obas_pkg::FRAC_BITS - SH);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [obas_pkg::THRESH_W-1:0] thr_reg;
    obas_pkg::reg_idx_t            reg_idx;
    logic                          cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = obas_pkg::reg_idx_t'(paddr[obas_pkg::CFG_ADDR_W-1]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= obas_pkg::THRESH_RESET;
        end
        else if (cfg_wr && (reg_idx == obas_pkg::REG_THRESH))
        begin
            thr_reg <= pwdata[obas_pkg::THRESH_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            obas_pkg::REG_THRESH: prdata = obas_pkg::CFG_DATA_W'(thr_reg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance: the whole datapath moves while the output buffer
    // has room.
    // ------------------------------------------------------------------
    logic [1:0] cnt_reg;
    logic       en;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    // stage 0: input capture
    logic            vld0_reg;
    logic [IN_W-1:0] in_reg;
    logic            op0_reg;

    // stage 1: width reduction, squares for the parallel test
    logic                   vld1_reg;
    logic                   op1_reg;
    logic signed [IW-1:0]   comp_s    [9];
    logic signed [IW-1:0]   comp1_reg [9];
    logic signed [2*IW-1:0] sqx_prod;
    logic signed [2*IW-1:0] sqy_prod;
    logic [2*IW-1:0]        sqx_reg;
    logic [2*IW-1:0]        sqy_reg;

    always_comb
    begin
        for (int j = 0; j < 9; j++)
        begin
            // floor shift of wide components: keep the top IW bits
            comp_s[j] = $signed(in_reg[j*CW + SH +: IW]);
        end
    end

    assign sqx_prod = comp_s[0] * comp_s[0];
    assign sqy_prod = comp_s[1] * comp_s[1];

    // stage 2: axis choice for opcode 1, working vectors
    logic               vld2_reg;
    logic [LW-1:0]      len2;
    logic               par;
    logic [2:0][VW-1:0] a_n;
    logic [2:0][VW-1:0] b_n;
    logic [2:0][VW-1:0] c_n;
    logic [2:0][VW-1:0] a2_reg;
    logic [2:0][VW-1:0] b2_reg;
    logic [2:0][VW-1:0] c2_reg;

    assign len2 = LW'(sqx_reg) + LW'(sqy_reg);
    assign par  = CMPW'(len2) <= CMPW'(thr_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_n[i] = VW'(comp1_reg[i]);
            b_n[i] = VW'(comp1_reg[3+i]);
            c_n[i] = VW'(comp1_reg[6+i]);
        end
        if (op1_reg)
        begin
            b_n = '0;
            c_n = '0;
            if (par)
            begin
                // a nearly along Z: use +X, cross = (0, a_z, -a_y)
                b_n[0] = UNIT;
                c_n[1] = VW'(comp1_reg[2]);
                c_n[2] = -VW'(comp1_reg[1]);
            end
            else
            begin
                // +Z, cross = (a_y, -a_x, 0)
                b_n[2] = UNIT;
                c_n[0] = VW'(comp1_reg[1]);
                c_n[1] = -VW'(comp1_reg[0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg  <= s_tdata[IN_W-1:0];
            op0_reg <= s_tuser;
            op1_reg <= op0_reg;
            comp1_reg <= comp_s;
            sqx_reg <= sqx_prod;
            sqy_reg <= sqy_prod;
            a2_reg  <= a_n;
            b2_reg  <= b_n;
            c2_reg  <= c_n;
        end
    end

    // ------------------------------------------------------------------
    // First projections: b and c onto a
    // ------------------------------------------------------------------
    logic               vld_pb;
    logic [2:0][VW-1:0] pb;
    logic [2:0][VW-1:0] pc;
    logic [6*VW-1:0]    tag_pb;
    logic [2:0][VW-1:0] b_pc;

    obas_proj #(
        .VW    (VW),
        .QW    (QW),
        .TAG_W (6 * VW)
    ) u_proj_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld2_reg),
        .y       (b2_reg),
        .u       (a2_reg),
        .tag_in  ({c2_reg, a2_reg}),
        .out_vld (vld_pb),
        .p       (pb),
        .tag_out (tag_pb)
    );

    obas_proj #(
        .VW    (VW),
        .QW    (QW),
        .TAG_W (3 * VW)
    ) u_proj_c (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld2_reg),
        .y       (c2_reg),
        .u       (a2_reg),
        .tag_in  (b2_reg),
        .out_vld (),
        .p       (pc),
        .tag_out (b_pc)
    );

    // stage X: u2 = b - proj(b, a), partial u3
    logic               vld3_reg;
    logic [2:0][VW-1:0] a_pb;
    logic [2:0][VW-1:0] c_pb;
    logic [2:0][VW-1:0] a3_reg;
    logic [2:0][VW-1:0] c3_reg;
    logic [2:0][VW-1:0] u2_reg;
    logic [2:0][VW-1:0] cp_reg;

    assign a_pb = tag_pb[3*VW-1:0];
    assign c_pb = tag_pb[6*VW-1:3*VW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg <= a_pb;
            c3_reg <= c_pb;
            for (int i = 0; i < 3; i++)
            begin
                u2_reg[i] <= b_pc[i] - pb[i];
                cp_reg[i] <= c_pb[i] - pc[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Second projection: original c onto u2
    // ------------------------------------------------------------------
    logic               vld_p2;
    logic [2:0][VW-1:0] pc2;
    logic [9*VW-1:0]    tag_p2;

    obas_proj #(
        .VW    (VW),
        .QW    (QW),
        .TAG_W (9 * VW)
    ) u_proj_2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld3_reg),
        .y       (c3_reg),
        .u       (u2_reg),
        .tag_in  ({cp_reg, u2_reg, a3_reg}),
        .out_vld (vld_p2),
        .p       (pc2),
        .tag_out (tag_p2)
    );

    // stage Y: u3 = c - proj(c, a) - proj(c, u2)
    logic               vld4_reg;
    logic [2:0][VW-1:0] a_p2;
    logic [2:0][VW-1:0] u2_p2;
    logic [2:0][VW-1:0] cp_p2;
    logic [2:0][VW-1:0] a4_reg;
    logic [2:0][VW-1:0] u2b_reg;
    logic [2:0][VW-1:0] u3_reg;

    assign a_p2  = tag_p2[3*VW-1:0];
    assign u2_p2 = tag_p2[6*VW-1:3*VW];
    assign cp_p2 = tag_p2[9*VW-1:6*VW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a4_reg  <= a_p2;
            u2b_reg <= u2_p2;
            for (int i = 0; i < 3; i++)
            begin
                u3_reg[i] <= cp_p2[i] - pc2[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalization of the three vectors in parallel
    // ------------------------------------------------------------------
    logic                            vld_out;
    logic [2:0][obas_pkg::OUT_W-1:0] e1;
    logic [2:0][obas_pkg::OUT_W-1:0] e2;
    logic [2:0][obas_pkg::OUT_W-1:0] e3;
    logic                            z1;
    logic                            z2;
    logic                            z3;

    obas_norm #(
        .VW (VW)
    ) u_norm_1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld4_reg),
        .u       (a4_reg),
        .out_vld (vld_out),
        .e       (e1),
        .zero    (z1)
    );

    obas_norm #(
        .VW (VW)
    ) u_norm_2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld4_reg),
        .u       (u2b_reg),
        .out_vld (),
        .e       (e2),
        .zero    (z2)
    );

    obas_norm #(
        .VW (VW)
    ) u_norm_3 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld4_reg),
        .u       (u3_reg),
        .out_vld (),
        .e       (e3),
        .zero    (z3)
    );

    // ------------------------------------------------------------------
    // Valid bits of the top-level stages
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= s_tvalid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld_pb;
            vld4_reg <= vld_p2;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output buffer; a full buffer freezes the pipeline
    // ------------------------------------------------------------------
    logic [OUT_DW:0] buf_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_next;
    logic            push;
    logic            pop;

    assign push = en && vld_out;
    assign pop  = m_tvalid && m_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= {z1 | z2 | z3, e3, e2, e1};
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = buf_reg[rd_ptr_reg][OUT_DW-1:0];
    assign m_tuser  = buf_reg[rd_ptr_reg][OUT_DW];

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for orthonormal_basis_3d_top (stream in/out, APB threshold).
// Directed table plus random vectors, checked against an integer basis predictor.
// Depends on obas_pkg and the RTL of orthonormal_basis_3d_top.
module testbench;

    localparam int DW = 144;                      // 9 x 16-bit components
    localparam int LAT = 160;                     // settle time after draining, longer than the pipeline

    typedef struct {
        logic [8:0][15:0] e;                      // e1_x .. e3_z, low to high
        logic             degen;
    } basis_t;

    typedef struct {
        bit               op;
        logic [DW-1:0]    d;
        bit               typed;
        basis_t           want;
    } row_t;

    // ---------------------------------------------------------------- DUT
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;                  // a_x..c_z, low to high
    logic s_tuser = 1'b0;                         // opcode
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [9*obas_pkg::OUT_W-1:0] m_tdata;        // e1_x..e3_z, low to high
    logic m_tuser;                                // degenerate
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [obas_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [obas_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [obas_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    orthonormal_basis_3d_top uut (.*);

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- state
    basis_t basis_q[$];                           // expected results, oldest first
    logic [obas_pkg::THRESH_W-1:0] thr_model = obas_pkg::THRESH_RESET;
    int errors = 0;
    int n_sent = 0, n_op1 = 0, n_got = 0, n_degen = 0, n_cfg = 0;
    bit calm = 1'b0;                              // no idling on either side
    bit no_gaps = 1'b0;                           // sender keeps offering
    bit hold_req = 1'b0;                          // receiver long hold-off request

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_got);
        errors++;
    endtask

    // ---------------------------------------------------------------- predictor
    function automatic longint dot3(input longint p[3], input longint q[3]);
        return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    endfunction

    // projection of y on u; zero when u has zero length
    function automatic void project_on(input longint y[3], input longint u[3],
                                       output longint p[3]);
        longint n, r;
        n = dot3(u, u);
        for (int i = 0; i < 3; i++)
            p[i] = 0;
        if (n != 0)
        begin
            // truncates to zero
            r = (dot3(y, u) * (longint'(1) << obas_pkg::RATIO_BITS)) / n;
            for (int i = 0; i < 3; i++)
                p[i] = (r * u[i] + (longint'(1) << (obas_pkg::RATIO_BITS - 1)))
                       >>> obas_pkg::RATIO_BITS;
        end
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v)
            bt >>= 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    // Q1.14 unit vector; returns 1 for a zero-length vector
    function automatic bit make_unit(input longint u[3], output logic [15:0] e[3]);
        longint unsigned n, sq, q, rem, mag;
        n = longint'(dot3(u, u));
        if (n == 0)
        begin
            for (int i = 0; i < 3; i++)
                e[i] = '0;
            return 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            sq = u[i] * u[i];
            q = (sq >= n) ? 1 : 0;
            rem = sq - q * n;
            for (int k = 0; k < obas_pkg::NORM_BITS; k++)
            begin
                rem <<= 1;
                q <<= 1;
                if (rem >= n)
                begin
                    rem -= n;
                    q |= 1;
                end
            end
            mag = (floor_sqrt(q) + 1) >> 1;
            e[i] = (u[i] < 0) ? 16'(-longint'(mag)) : 16'(mag);
        end
        return 1'b0;
    endfunction

    function automatic basis_t predict_basis(input bit op, input logic [DW-1:0] d,
                                             input logic [obas_pkg::THRESH_W-1:0] thr);
        longint a[3], b[3], c[3], u2[3], u3[3], p[3], q[3];
        longint len2;
        logic [15:0] e[3];
        basis_t r;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'($signed(d[16*i +: 16]));
            b[i] = longint'($signed(d[16*(3+i) +: 16]));
            c[i] = longint'($signed(d[16*(6+i) +: 16]));
        end
        if (op)
        begin
            // helper axis +Z, or +X when a lies too close to the Z axis
            len2 = a[0] * a[0] + a[1] * a[1];
            b = '{0, 0, 4096};
            c = '{a[1], -a[0], 0};
            if (longint'(unsigned'(len2)) <= longint'({30'd0, thr}))
            begin
                b = '{4096, 0, 0};
                c = '{0, a[2], -a[1]};
            end
        end
        project_on(b, a, p);
        for (int i = 0; i < 3; i++)
            u2[i] = b[i] - p[i];
        project_on(c, a, p);
        project_on(c, u2, q);
        for (int i = 0; i < 3; i++)
            u3[i] = c[i] - p[i] - q[i];
        r.degen = make_unit(a, e);
        for (int i = 0; i < 3; i++) r.e[i] = e[i];
        r.degen |= make_unit(u2, e);
        for (int i = 0; i < 3; i++) r.e[3+i] = e[i];
        r.degen |= make_unit(u3, e);
        for (int i = 0; i < 3; i++) r.e[6+i] = e[i];
        return r;
    endfunction

    function automatic logic [DW-1:0] vec9(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        return {16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by), 16'(bx),
                16'(az), 16'(ay), 16'(ax)};
    endfunction

    // ---------------------------------------------------------------- checker
    always @(posedge clk)
    begin
        basis_t w;
        if (m_tvalid && m_tready)
        begin
            if (basis_q.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
            end
            else
            begin
                w = basis_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_tdata[16*i +: 16] !== w.e[i])
                        report_mismatch($sformatf("e%0d_%s", i / 3 + 1, (i % 3 == 0) ? "x" :
                                        (i % 3 == 1) ? "y" : "z"),
                                        $signed(m_tdata[16*i +: 16]), $signed(w.e[i]));
                if (m_tuser !== w.degen)
                    report_mismatch("degenerate", m_tuser, w.degen);
                n_degen += w.degen;
            end
            n_got++;
        end
    end

    // ---------------------------------------------------------------- receiver
    // random stall bursts; one long hold-off on request, counted here
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // ---------------------------------------------------------------- sender
    // entered and left at a falling edge
    task automatic send_beat(input row_t r);
        if (!calm && !no_gaps && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= r.d;
        do @(posedge clk); while (!s_tready);
        basis_q.push_back(r.typed ? r.want : predict_basis(r.op, r.d, thr_model));
        n_sent++;
        n_op1 += r.op;
        @(negedge clk);
    endtask

    // stop offering until every expected result is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (basis_q.size() != 0)
            @(negedge clk);
        repeat (LAT) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [obas_pkg::THRESH_W-1:0] v);
        paddr <= obas_pkg::CFG_ADDR_W'(8 * int'(obas_pkg::REG_THRESH));
        pwdata <= obas_pkg::CFG_DATA_W'(v);
        pwrite <= 1'b1;
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;                          // read back: new setup cycle
        thr_model = v;
        n_cfg++;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[obas_pkg::THRESH_W-1:0] !== v)
            report_mismatch("parallel_threshold readback", int'(prdata), int'(v));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic row_t random_row();
        row_t r;
        logic [15:0] k[9];
        int lo;
        for (int i = 0; i < 9; i++)
            k[i] = 16'($urandom);
        r.typed = 1'b0;
        r.op = 1'b0;
        case ($urandom_range(0, 9))
            4:  for (int i = 0; i < 9; i++)   // small values: rounding, near-degenerate
                    k[i] = 16'($urandom_range(0, 16) - 8);
            5:  begin                         // b along a or opposite, c mixes components of a
                    lo = $urandom_range(0, 1);
                    for (int i = 0; i < 3; i++)
                    begin
                        k[i] = k[i] >>> 1;
                        k[3+i] = lo ? k[i] : -k[i];
                        k[6+i] = $urandom_range(0, 1) ? k[i] : k[6+i];
                    end
                end
            6:  begin                         // one zero vector
                    lo = 3 * $urandom_range(0, 2);
                    for (int i = 0; i < 3; i++)
                        k[lo+i] = '0;
                end
            7, 8: r.op = 1'b1;
            9:  begin                         // a near the Z axis
                    r.op = 1'b1;
                    k[0] = 16'($urandom_range(0, 26) - 13);
                    k[1] = 16'($urandom_range(0, 26) - 13);
                end
            default: ;
        endcase
        r.d = {k[8], k[7], k[6], k[5], k[4], k[3], k[2], k[1], k[0]};
        return r;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_beat(random_row());
    endtask

    // ---------------------------------------------------------------- main
    initial
    begin
        row_t table_q[$];
        row_t r;
        basis_t ident, zero3, xbasis, op1zero;
        int guard;

        ident.e = '0;
        ident.e[0] = 16384; ident.e[4] = 16384; ident.e[8] = 16384;
        ident.degen = 1'b0;
        zero3.e = '0;
        zero3.degen = 1'b1;
        xbasis.e = '0;                            // a on +Z, helper +X
        xbasis.e[2] = 16384; xbasis.e[3] = 16384; xbasis.e[7] = 16384;
        xbasis.degen = 1'b0;
        op1zero.e = '0;                           // a zero: only the +X helper survives
        op1zero.e[3] = 16384;
        op1zero.degen = 1'b1;

        // op, data, typed, expected
        table_q.push_back('{1'b0, vec9(4096, 0, 0, 0, 4096, 0, 0, 0, 4096), 1'b1, ident});
        table_q.push_back('{1'b0, vec9(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero3});
        table_q.push_back('{1'b1, vec9(0, 0, 4096, 0, 0, 0, 0, 0, 0), 1'b1, xbasis});
        table_q.push_back('{1'b1, vec9(0, 0, 0, 1, 2, 3, 4, 5, 6), 1'b1, op1zero});
        table_q.push_back('{1'b0, vec9(32767, 32767, 32767, 32767, 32767, 32767,
                                       32767, 32767, 32767), 1'b0, zero3});
        table_q.push_back('{1'b0, vec9(-32768, -32768, -32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768), 1'b0, zero3});
        table_q.push_back('{1'b0, vec9(-32768, 32767, 0, 32767, -32768, 0,
                                       0, 0, -32768), 1'b0, zero3});
        table_q.push_back('{1'b0, vec9(32767, -32768, 32767, -32768, 32767, -32768,
                                       1, -1, 1), 1'b0, zero3});
        table_q.push_back('{1'b0, vec9(1, 0, 0, 1, 1, 0, 1, 1, 1), 1'b0, zero3});
        table_q.push_back('{1'b0, vec9(100, 200, 300, 200, 400, 600, 5, -7, 9), 1'b0, zero3});
        table_q.push_back('{1'b0, vec9(3, 4, 0, 0, 0, 0, -4, 3, 0), 1'b0, zero3});
        table_q.push_back('{1'b1, vec9(32767, -32768, -32768, 7, 7, 7, 7, 7, 7), 1'b0, zero3});
        table_q.push_back('{1'b1, vec9(-32768, -32768, 32767, 0, 0, 0, 0, 0, 0), 1'b0, zero3});
        table_q.push_back('{1'b1, vec9(12, 4, 4096, 0, 0, 0, 0, 0, 0), 1'b0, zero3});
        table_q.push_back('{1'b1, vec9(13, 0, -4096, 0, 0, 0, 0, 0, 0), 1'b0, zero3});
        table_q.push_back('{1'b1, vec9(12, 6, 1, -1, -1, -1, -1, -1, -1), 1'b0, zero3});
        table_q.push_back('{1'b1, vec9(0, 0, -1, 0, 0, 0, 0, 0, 0), 1'b0, zero3});
        table_q.push_back('{1'b1, vec9(1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero3});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset value of the threshold, then directed rows
        foreach (table_q[i])
            send_beat(table_q[i]);
        random_phase(40);

        // threshold extremes: +X only for a on the Z axis, then always +X
        drain();
        cfg_write('0);
        random_phase(50);
        drain();
        cfg_write({obas_pkg::THRESH_W{1'b1}});
        random_phase(50);

        // long receiver hold-off while the sender keeps pushing: pipe fills, s_tready drops
        drain();
        cfg_write(obas_pkg::THRESH_W'({$urandom(), $urandom()}));
        hold_req = 1'b1;
        no_gaps = 1'b1;
        random_phase(160);
        no_gaps = 1'b0;
        drain();                                  // sender waits for everything to return

        cfg_write(obas_pkg::THRESH_RESET);
        random_phase(70);
        calm = 1'b1;                              // closing stretch: full rate both sides
        random_phase(60);

        s_tvalid <= 1'b0;
        guard = 0;
        while (basis_q.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LAT) @(negedge clk);
        if (basis_q.size() != 0)
            report_mismatch("expected results never arrived", basis_q.size(), 0);

        $display("Sent %0d beats (%0d basis-from-a), checked %0d results, %0d degenerate.",
                 n_sent, n_op1, n_got, n_degen);
        $display("Threshold written %0d times incl. 0 and all-ones; long output stall exercised.",
                 n_cfg);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("Timeout waiting for the pipeline");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
